// ----- hw/rtl/lsp_pkg.sv -----
// Package for the limit switch positioner: position, goal and direction codes,
// reset constants and the control state struct. Depends on nothing.
package lsp_pkg;

    // Operation codes of an input item.
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_GOTO = 1'b1;

    // Decoded positions; also the codes of a goto target.
    localparam logic [2:0] POS_LEFT    = 3'd0;
    localparam logic [2:0] POS_MID     = 3'd1;
    localparam logic [2:0] POS_RIGHT   = 3'd2;
    localparam logic [2:0] POS_UNKNOWN = 3'd3;
    localparam logic [2:0] POS_ERROR   = 3'd4;

    // Goal codes.
    localparam logic [1:0] GOAL_LEFT  = 2'd0;
    localparam logic [1:0] GOAL_MID   = 2'd1;
    localparam logic [1:0] GOAL_RIGHT = 2'd2;
    localparam logic [1:0] GOAL_NONE  = 2'd3;

    // Motor states; bit 1 drives bridge input one, bit 0 bridge input two.
    localparam logic [1:0] DIR_COAST = 2'd0;
    localparam logic [1:0] DIR_LEFT  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_BRAKE = 2'd3;

    // Field widths fixed by the item format.
    localparam int MST_BITS   = 23;
    localparam int LIMIT_BITS = 24;
    // Widest value ever loaded into the timer: three times the search timeout.
    localparam int LOAD_BITS  = 25;

    // Reset values and defaults.
    localparam int TIMER_BITS_DEF = 24;
    localparam int INIT_TICKS     = 200;
    localparam logic [MST_BITS-1:0] MST_RESET = 23'd2000;

    // Position, goal and motor state travelling between top level and step logic.
    typedef struct packed {
        logic [2:0] pos;
        logic [1:0] goal;
        logic [1:0] dir;
    } t_ctl;

endpackage

// ----- hw/rtl/lsp_step.sv -----
// Next-state logic of the positioner for one item (tick or goto).
// Depends on lsp_pkg.
module lsp_step #(
    parameter int TIMER_BITS = lsp_pkg::TIMER_BITS_DEF
) (
    input  logic                              i_op,
    input  logic                              i_left_switch,
    input  logic                              i_mid_switch,
    input  logic                              i_right_switch,
    input  logic [2:0]                        i_target,
    input  logic [lsp_pkg::LIMIT_BITS-1:0]    i_run_limit,
    input  logic [lsp_pkg::MST_BITS-1:0]      i_mst,
    input  lsp_pkg::t_ctl                     i_ctl,
    input  logic [TIMER_BITS-1:0]             i_run_count,
    input  logic                              i_run_active,
    output lsp_pkg::t_ctl                     o_ctl,
    output logic [TIMER_BITS-1:0]             o_run_count,
    output logic                              o_run_active
);

    localparam int LW = lsp_pkg::LOAD_BITS;
    localparam int MW = (TIMER_BITS > LW) ? TIMER_BITS : LW;

    // Saturate a load value to the largest count the timer holds.
    function automatic logic [TIMER_BITS-1:0] f_sat(input logic [LW-1:0] v);
        logic [MW-1:0] vx;
        logic [MW-1:0] top;
        vx  = MW'(v);
        top = MW'({TIMER_BITS{1'b1}});
        if (vx > top) begin
            f_sat = top[TIMER_BITS-1:0];
        end else begin
            f_sat = vx[TIMER_BITS-1:0];
        end
    endfunction

    logic [LW-1:0]  w_mst_load;
    logic [LW-1:0]  w_rev_load;
    logic [2:0]     w_decoded;

    // Search timeout and three times it for the reversal.
    assign w_mst_load = LW'(i_mst);
    assign w_rev_load = w_mst_load + (w_mst_load << 1);

    // Exactly one switch pressed (low) names the position.
    always_comb begin
        case ({i_left_switch, i_mid_switch, i_right_switch})
            3'b011:  w_decoded = lsp_pkg::POS_LEFT;
            3'b101:  w_decoded = lsp_pkg::POS_MID;
            3'b110:  w_decoded = lsp_pkg::POS_RIGHT;
            3'b111:  w_decoded = lsp_pkg::POS_UNKNOWN;
            default: w_decoded = lsp_pkg::POS_ERROR;
        endcase
    end

    // Tick: decode, count down, handle expiry and arrival. Goto: set goal and motor.
    always_comb begin
        o_ctl        = i_ctl;
        o_run_count  = i_run_count;
        o_run_active = i_run_active;
        if (i_op == lsp_pkg::OP_GOTO) begin
            if (!(i_ctl.pos == lsp_pkg::POS_ERROR || i_ctl.pos == i_target)) begin
                if (i_run_limit != '0) begin
                    o_run_count  = f_sat(LW'(i_run_limit));
                    o_run_active = 1'b1;
                end
                case (i_target)
                    lsp_pkg::POS_LEFT: begin
                        o_ctl.goal = lsp_pkg::GOAL_LEFT;
                        o_ctl.dir  = lsp_pkg::DIR_LEFT;
                    end
                    lsp_pkg::POS_RIGHT: begin
                        o_ctl.goal = lsp_pkg::GOAL_RIGHT;
                        o_ctl.dir  = lsp_pkg::DIR_RIGHT;
                    end
                    lsp_pkg::POS_MID: begin
                        o_ctl.goal = lsp_pkg::GOAL_MID;
                        case (i_ctl.pos)
                            lsp_pkg::POS_LEFT:  o_ctl.dir = lsp_pkg::DIR_RIGHT;
                            lsp_pkg::POS_RIGHT: o_ctl.dir = lsp_pkg::DIR_LEFT;
                            default: begin
                                // Unknown position: search leftward first.
                                o_ctl.dir    = lsp_pkg::DIR_LEFT;
                                o_run_count  = f_sat(w_mst_load);
                                o_run_active = 1'b1;
                            end
                        endcase
                    end
                    default: begin
                        o_ctl.goal   = lsp_pkg::GOAL_NONE;
                        o_ctl.dir    = lsp_pkg::DIR_COAST;
                        o_run_active = 1'b0;
                    end
                endcase
            end
        end else begin
            o_ctl.pos = w_decoded;
            if (i_run_active && i_run_count != '0) begin
                o_run_count = i_run_count - TIMER_BITS'(1);
            end
            if (i_run_active && o_run_count == '0) begin
                if (i_ctl.goal == lsp_pkg::GOAL_MID && i_ctl.dir == lsp_pkg::DIR_LEFT) begin
                    // Mid not found going left: reverse with a longer timeout.
                    o_ctl.dir    = lsp_pkg::DIR_RIGHT;
                    o_run_count  = f_sat(w_rev_load);
                    o_run_active = 1'b1;
                end else begin
                    o_ctl.goal   = lsp_pkg::GOAL_NONE;
                    o_ctl.dir    = lsp_pkg::DIR_COAST;
                    o_run_active = 1'b0;
                end
            end
            if (o_ctl.goal != lsp_pkg::GOAL_NONE && w_decoded == {1'b0, o_ctl.goal}) begin
                // Arrived: brake and stop the timer.
                o_ctl.goal   = lsp_pkg::GOAL_NONE;
                o_ctl.dir    = lsp_pkg::DIR_BRAKE;
                o_run_active = 1'b0;
            end
        end
    end

endmodule

// ----- hw/rtl/limit_switch_positioner_unit.sv -----
// Top level of the limit switch positioner: input register, state, result register.
// Depends on lsp_pkg and lsp_step.
//
// Positions an H-bridge motor between three active-low limit switches. Each item,
// a millisecond tick with switch levels or a goto command, gives exactly one result
// with the bridge levels, decoded position, goal and motor state after that item.
// An item is registered, passes the step logic and lands in the result register, so
// one item is taken every cycle unless the result side stalls; a stalled result
// holds up one further item in the input register before the input side stalls.
// The run timer is TIMER_BITS wide; every load saturates at its top. The user must
// write the search timeout register only while no item is in flight; the block does not check it.
module limit_switch_positioner_unit #(
    parameter int TIMER_BITS = lsp_pkg::TIMER_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Configuration
    input  logic                            i_cfg_we,
    input  logic [lsp_pkg::MST_BITS-1:0]    i_cfg_wdata,
    // Input items
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic                            i_operation,
    input  logic                            i_left_switch,
    input  logic                            i_mid_switch,
    input  logic                            i_right_switch,
    input  logic [2:0]                      i_target,
    input  logic [lsp_pkg::LIMIT_BITS-1:0]  i_run_limit,
    // Result items
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic                            o_drive_a,
    output logic                            o_drive_b,
    output logic [2:0]                      o_position,
    output logic [1:0]                      o_goal,
    output logic [1:0]                      o_direction
);

    logic                            r_in_valid;
    logic                            r_in_op;
    logic                            r_in_left;
    logic                            r_in_mid;
    logic                            r_in_right;
    logic [2:0]                      r_in_target;
    logic [lsp_pkg::LIMIT_BITS-1:0]  r_in_limit;

    logic [lsp_pkg::MST_BITS-1:0]    r_mst;
    lsp_pkg::t_ctl                   r_ctl;
    logic [TIMER_BITS-1:0]           r_run_count;
    logic                            r_run_active;

    lsp_pkg::t_ctl                   n_ctl;
    logic [TIMER_BITS-1:0]           n_run_count;
    logic                            n_run_active;

    logic                            r_out_valid;
    lsp_pkg::t_ctl                   r_out_ctl;

    logic                            w_out_ready;
    logic                            w_fire;
    logic                            w_in_accept;

    // Handshake: the result register frees when empty or when taken.
    assign w_out_ready = !r_out_valid || !i_out_stall;
    assign w_fire      = r_in_valid && w_out_ready;
    assign o_in_stall  = r_in_valid && !w_out_ready;
    assign w_in_accept = i_in_valid && !o_in_stall;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mst <= lsp_pkg::MST_RESET;
        end else if (i_cfg_we) begin
            r_mst <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_in_op     <= i_operation;
            r_in_left   <= i_left_switch;
            r_in_mid    <= i_mid_switch;
            r_in_right  <= i_right_switch;
            r_in_target <= i_target;
            r_in_limit  <= i_run_limit;
        end
    end

    // Step logic for the item in the input register.
    lsp_step #(
        .TIMER_BITS (TIMER_BITS)
    ) u_step (
        .i_op           (r_in_op),
        .i_left_switch  (r_in_left),
        .i_mid_switch   (r_in_mid),
        .i_right_switch (r_in_right),
        .i_target       (r_in_target),
        .i_run_limit    (r_in_limit),
        .i_mst          (r_mst),
        .i_ctl          (r_ctl),
        .i_run_count    (r_run_count),
        .i_run_active   (r_run_active),
        .o_ctl          (n_ctl),
        .o_run_count    (n_run_count),
        .o_run_active   (n_run_active)
    );

    // Positioner state advances once per item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl.pos    <= lsp_pkg::POS_UNKNOWN;
            r_ctl.goal   <= lsp_pkg::GOAL_NONE;
            r_ctl.dir    <= lsp_pkg::DIR_COAST;
            r_run_count  <= TIMER_BITS'(lsp_pkg::INIT_TICKS);
            r_run_active <= 1'b1;
        end else if (w_fire) begin
            r_ctl        <= n_ctl;
            r_run_count  <= n_run_count;
            r_run_active <= n_run_active;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out_ctl <= n_ctl;
        end
    end

    // The bridge levels follow the motor state bit for bit.
    assign o_out_valid = r_out_valid;
    assign o_drive_a   = r_out_ctl.dir[1];
    assign o_drive_b   = r_out_ctl.dir[0];
    assign o_position  = r_out_ctl.pos;
    assign o_goal      = r_out_ctl.goal;
    assign o_direction = r_out_ctl.dir;

    // A braking motor has reached its goal, so no goal remains.
    a_brake_no_goal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.dir == lsp_pkg::DIR_BRAKE |-> r_ctl.goal == lsp_pkg::GOAL_NONE)
        else $error("brake with a goal still set");

    // While a goal is pending the motor runs left or right.
    a_goal_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.goal != lsp_pkg::GOAL_NONE |->
            (r_ctl.dir == lsp_pkg::DIR_LEFT || r_ctl.dir == lsp_pkg::DIR_RIGHT))
        else $error("goal pending without the motor running");

    // A held item is not dropped while the result side is blocked.
    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !w_out_ready) |=> r_in_valid)
        else $error("input item lost under stall");

    // A result leaves only when it was taken.
    a_result_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall) |=> r_out_valid)
        else $error("stalled result dropped");

endmodule

// ----- tb/sv/limit_switch_positioner_unit_tb.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for limit_switch_positioner_unit: random and directed items,
// checked by a scoreboard class that predicts the motor controller's state after each item.
// Depends on lsp_pkg and limit_switch_positioner_unit.
module limit_switch_positioner_unit_tb;

    localparam int TIMER_BITS      = lsp_pkg::TIMER_BITS_DEF;
    localparam int MST_BITS        = lsp_pkg::MST_BITS;
    localparam int LIMIT_BITS      = lsp_pkg::LIMIT_BITS;
    localparam int RESET_CYCLES    = 11;
    localparam int DRAIN_CYCLES    = 4;
    localparam int WATCHDOG_LIMIT  = 5000;
    localparam int IDLE_PERCENT    = 19;
    localparam int REVERSE_FACTOR  = 3;
    localparam int NUM_PHASES      = 12;
    localparam int PHASE_ITEMS     = 150;
    localparam int FIRST_ITEMS     = 125;
    localparam int CALM_PHASE      = 6;
    localparam int PRESSURE_AT     = 600;
    localparam int HOLD_LEN        = 80;
    localparam logic [MST_BITS-1:0] MST_TOP = 23'd5592405;
    localparam logic [MST_BITS-1:0] MST_ALL = 23'h7FFFFF;

    // One input item as offered to the block.
    typedef struct packed {
        logic                  operation;
        logic                  left_sw;
        logic                  mid_sw;
        logic                  right_sw;
        logic [2:0]            target;
        logic [LIMIT_BITS-1:0] run_limit;
    } t_item;

    // One result item as seen on the output ports.
    typedef struct packed {
        logic       drive_a;
        logic       drive_b;
        logic [2:0] position;
        logic [1:0] goal;
        logic [1:0] direction;
    } t_result;

    // Tracks the positioner's state and holds the results still to come.
    class lsp_scoreboard;
        logic [2:0]          pos;
        logic [1:0]          goal;
        logic [1:0]          dir;
        logic [1:0]          drive;
        longint unsigned     run_count;
        bit                  run_active;
        logic [MST_BITS-1:0] search_ticks;
        t_result             expected_q[$];
        int                  failures;

        function void reset_state();
            search_ticks = lsp_pkg::MST_RESET;
            pos          = lsp_pkg::POS_UNKNOWN;
            goal         = lsp_pkg::GOAL_NONE;
            dir          = lsp_pkg::DIR_COAST;
            drive        = lsp_pkg::DIR_COAST;
            run_count    = 64'(lsp_pkg::INIT_TICKS);
            run_active   = 1'b1;
        endfunction

        function void set_search_ticks(logic [MST_BITS-1:0] ticks);
            search_ticks = ticks;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // Every load saturates at the top of the timer.
        function void load_timer(longint unsigned ticks);
            longint unsigned top;
            top        = (64'd1 << TIMER_BITS) - 1;
            run_count  = (ticks > top) ? top : ticks;
            run_active = 1'b1;
        endfunction

        // The bridge levels follow the motor state bit for bit.
        function void set_dir(logic [1:0] d);
            dir   = d;
            drive = d;
        endfunction

        function void coast_stop();
            goal       = lsp_pkg::GOAL_NONE;
            run_active = 1'b0;
            set_dir(lsp_pkg::DIR_COAST);
        endfunction

        // Applies one accepted item and queues the result it gives.
        function void note_item(t_item it);
            t_result want;
            if (it.operation == lsp_pkg::OP_TICK) begin
                // Exactly one pressed switch (low) gives its position.
                case ({it.left_sw, it.mid_sw, it.right_sw})
                    3'b011:  pos = lsp_pkg::POS_LEFT;
                    3'b101:  pos = lsp_pkg::POS_MID;
                    3'b110:  pos = lsp_pkg::POS_RIGHT;
                    3'b111:  pos = lsp_pkg::POS_UNKNOWN;
                    default: pos = lsp_pkg::POS_ERROR;
                endcase
                if (run_active && run_count != 0) run_count--;
                if (run_active && run_count == 0) begin
                    if (goal == lsp_pkg::GOAL_MID && dir == lsp_pkg::DIR_LEFT) begin
                        set_dir(lsp_pkg::DIR_RIGHT);
                        load_timer(REVERSE_FACTOR * 64'(search_ticks));
                    end else begin
                        coast_stop();
                    end
                end
                if (goal != lsp_pkg::GOAL_NONE && pos == {1'b0, goal}) begin
                    goal       = lsp_pkg::GOAL_NONE;
                    run_active = 1'b0;
                    set_dir(lsp_pkg::DIR_BRAKE);
                end
            end else if (pos != lsp_pkg::POS_ERROR && pos != it.target) begin
                if (it.run_limit != 0) load_timer(64'(it.run_limit));
                case (it.target)
                    lsp_pkg::POS_LEFT: begin
                        goal = lsp_pkg::GOAL_LEFT;
                        set_dir(lsp_pkg::DIR_LEFT);
                    end
                    lsp_pkg::POS_RIGHT: begin
                        goal = lsp_pkg::GOAL_RIGHT;
                        set_dir(lsp_pkg::DIR_RIGHT);
                    end
                    lsp_pkg::POS_MID: begin
                        goal = lsp_pkg::GOAL_MID;
                        if (pos == lsp_pkg::POS_LEFT) begin
                            set_dir(lsp_pkg::DIR_RIGHT);
                        end else if (pos == lsp_pkg::POS_RIGHT) begin
                            set_dir(lsp_pkg::DIR_LEFT);
                        end else begin
                            // Searching from an unknown place: go left on the search timeout.
                            set_dir(lsp_pkg::DIR_LEFT);
                            load_timer(64'(search_ticks));
                        end
                    end
                    default: coast_stop();
                endcase
            end
            want.drive_a   = drive[1];
            want.drive_b   = drive[0];
            want.position  = pos;
            want.goal      = goal;
            want.direction = dir;
            expected_q.push_back(want);
        endfunction

        function void compare_field(string name, logic [2:0] want, logic [2:0] got);
            if (got !== want) begin
                failures++;
                $error("%s: expected %0d, got %0d", name, want, got);
            end
        endfunction

        function void check_result(t_result got);
            t_result want;
            if (expected_q.size() == 0) begin
                failures++;
                $error("result with no item waiting: position %0d goal %0d direction %0d",
                       got.position, got.goal, got.direction);
            end else begin
                want = expected_q.pop_front();
                compare_field("drive_a", 3'(want.drive_a), 3'(got.drive_a));
                compare_field("drive_b", 3'(want.drive_b), 3'(got.drive_b));
                compare_field("position", want.position, got.position);
                compare_field("goal", 3'(want.goal), 3'(got.goal));
                compare_field("direction", 3'(want.direction), 3'(got.direction));
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [MST_BITS-1:0]   i_cfg_wdata    = '0;
    logic                  i_in_valid     = 1'b0;
    logic                  o_in_stall;
    logic                  i_operation    = lsp_pkg::OP_TICK;
    logic                  i_left_switch  = 1'b1;
    logic                  i_mid_switch   = 1'b1;
    logic                  i_right_switch = 1'b1;
    logic [2:0]            i_target       = '0;
    logic [LIMIT_BITS-1:0] i_run_limit    = '0;
    logic                  o_out_valid;
    logic                  i_out_stall    = 1'b0;
    logic                  o_drive_a;
    logic                  o_drive_b;
    logic [2:0]            o_position;
    logic [1:0]            o_goal;
    logic [1:0]            o_direction;

    lsp_scoreboard sb;
    bit            calm = 1'b0;
    bit            held = 1'b0;
    int            results_seen = 0;
    int            hold_cycles = 0;
    int            quiet_cycles = 0;

    limit_switch_positioner_unit #(
        .TIMER_BITS(TIMER_BITS)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_operation    (i_operation),
        .i_left_switch  (i_left_switch),
        .i_mid_switch   (i_mid_switch),
        .i_right_switch (i_right_switch),
        .i_target       (i_target),
        .i_run_limit    (i_run_limit),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_drive_a      (o_drive_a),
        .o_drive_b      (o_drive_b),
        .o_position     (o_position),
        .o_goal         (o_goal),
        .o_direction    (o_direction)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Result side: check each accepted result, stall at random, and hold off once
    // for a long stretch so that the block fills up.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check_result({o_drive_a, o_drive_b, o_position, o_goal, o_direction});
            results_seen++;
        end
        if (hold_cycles != 0) begin
            i_out_stall <= 1'b1;
            hold_cycles--;
        end else if (results_seen >= PRESSURE_AT && !held) begin
            held        = 1'b1;
            hold_cycles = HOLD_LEN - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < IDLE_PERCENT);
        end
    end

    // Ends the run when nothing has moved on either side for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Offers one item, after idle cycles drawn at random, and waits until it is taken.
    task automatic put_item(input t_item it);
        while (!calm && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_operation    <= it.operation;
        i_left_switch  <= it.left_sw;
        i_mid_switch   <= it.mid_sw;
        i_right_switch <= it.right_sw;
        i_target       <= it.target;
        i_run_limit    <= it.run_limit;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(it);
    endtask

    task automatic tick(input logic l, input logic m, input logic r);
        t_item it;
        it = '{lsp_pkg::OP_TICK, l, m, r, 3'd0, '0};
        put_item(it);
    endtask

    task automatic go(input logic [2:0] tgt, input logic [LIMIT_BITS-1:0] limit);
        t_item it;
        it = '{lsp_pkg::OP_GOTO, 1'($urandom_range(1)), 1'($urandom_range(1)),
               1'($urandom_range(1)), tgt, limit};
        put_item(it);
    endtask

    // Mostly plausible switch readings and reachable goals, with some noise.
    function automatic t_item random_item();
        t_item it;
        int    pick;
        it   = '{lsp_pkg::OP_TICK, 1'b1, 1'b1, 1'b1, 3'($urandom_range(7)), 24'($urandom)};
        pick = $urandom_range(99);
        if (pick < 18) begin
            it.operation = lsp_pkg::OP_GOTO;
            pick         = $urandom_range(99);
            if (pick < 70) begin
                it.target = 3'($urandom_range(lsp_pkg::POS_LEFT, lsp_pkg::POS_RIGHT));
            end else if (pick < 90) begin
                it.target = 3'($urandom_range(lsp_pkg::POS_UNKNOWN, lsp_pkg::POS_ERROR));
            end else begin
                it.target = 3'($urandom_range(5, 7));
            end
            pick = $urandom_range(99);
            if (pick < 40) it.run_limit = '0;
            else if (pick < 85) it.run_limit = 24'($urandom_range(1, 40));
        end else if (pick < 46) begin
            it.left_sw  = 1'b0;
        end else if (pick < 60) begin
            it.mid_sw   = 1'b0;
        end else if (pick < 74) begin
            it.right_sw = 1'b0;
        end else if (pick < 86) begin
            {it.left_sw, it.mid_sw, it.right_sw} = 3'($urandom_range(7));
        end
        return it;
    endfunction

    task automatic run_random(input int count);
        for (int n = 0; n < count; n++) put_item(random_item());
    endtask

    // Writes the search timeout once every result is back and the block is quiet.
    task automatic write_search_ticks(input logic [MST_BITS-1:0] ticks);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ticks;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.set_search_ticks(ticks);
    endtask

    function automatic logic [MST_BITS-1:0] phase_setting(input int p);
        case (p)
            0:       return 23'd1;
            1:       return '0;
            2:       return MST_TOP;
            3:       return MST_ALL;
            4:       return lsp_pkg::MST_RESET;
            default: return 23'($urandom_range(1, 40));
        endcase
    endfunction

    initial begin
        sb = new();
        sb.reset_state();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening on the reset search timeout.
        tick(1'b1, 1'b1, 1'b1);
        go(lsp_pkg::POS_LEFT, '0);
        tick(1'b0, 1'b1, 1'b1);
        go(lsp_pkg::POS_LEFT, 24'hFFFFFF);      // already there: nothing changes
        go(lsp_pkg::POS_MID, 24'hFFFFFF);
        tick(1'b1, 1'b1, 1'b1);
        tick(1'b1, 1'b0, 1'b1);                 // arrival brakes
        go(lsp_pkg::POS_RIGHT, 24'd3);
        tick(1'b1, 1'b1, 1'b1);
        tick(1'b1, 1'b1, 1'b1);
        tick(1'b1, 1'b1, 1'b1);                 // run limit expires: coast
        tick(1'b1, 1'b1, 1'b0);
        go(lsp_pkg::POS_MID, '0);
        go(lsp_pkg::POS_UNKNOWN, 24'd5);
        tick(1'b0, 1'b0, 1'b1);                 // two switches pressed
        go(lsp_pkg::POS_LEFT, 24'd7);           // ignored while in error
        tick(1'b0, 1'b0, 1'b0);
        tick(1'b1, 1'b1, 1'b1);
        go(lsp_pkg::POS_UNKNOWN, '0);
        go(lsp_pkg::POS_MID, 24'd9);            // search timeout replaces the run limit
        go(lsp_pkg::POS_ERROR, '0);
        go(3'd5, 24'd1);
        go(3'd6, '0);
        go(3'd7, 24'hAAAAAA);
        go(lsp_pkg::POS_RIGHT, 24'h555555);
        run_random(FIRST_ITEMS);

        // Phases over several search timeouts, each opening with a search for mid.
        for (int p = 0; p < NUM_PHASES; p++) begin
            calm = (p == CALM_PHASE);
            write_search_ticks(phase_setting(p));
            tick(1'b1, 1'b1, 1'b1);
            go(lsp_pkg::POS_MID, '0);
            tick(1'b1, 1'b1, 1'b1);
            tick(1'b1, 1'b1, 1'b1);
            run_random(PHASE_ITEMS);
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.failures == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// ----- limit_switch_positioner_unit.f -----
hw/rtl/lsp_pkg.sv
hw/rtl/lsp_step.sv
hw/rtl/limit_switch_positioner_unit.sv
tb/sv/limit_switch_positioner_unit_tb.sv
